// ----- hw/rtl/sorted_list_table_top_defines.svh -----
// Assertion helpers for the sorted list table.
`ifndef SORTED_LIST_TABLE_TOP_DEFINES_SVH
`define SORTED_LIST_TABLE_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define SLT_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off during reset.
`define SLT_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hw/rtl/slt_pkg.sv -----
package slt_pkg;

   localparam int VALUE_W = 32;
   localparam int INDEX_W = 6;
   localparam int COUNT_W = 7;
   localparam int ACTION_W = 2;
   localparam int STATUS_W = 2;

   localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_REMOVE = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_DUMP   = 2'd2;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_RANGE = 2'd2,
      ST_FULL  = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      OP_NONE,
      OP_INSERT,
      OP_REMOVE,
      OP_ROTATE
   } op_type;

   typedef enum logic [1:0] {
      RK_SINGLE,
      RK_DUMP_FIRST,
      RK_DUMP_NEXT
   } rsp_kind_type;

   typedef struct packed {
      logic         load_req;
      op_type       op;
      logic         load_rsp;
      rsp_kind_type kind;
      status_type   status;
   } cmd_type;

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic                empty;
      logic                full;
      logic                index_bad;
      logic                rsp_last;
      logic                rsp_dump;
   } stat_type;

endpackage

// ----- hw/rtl/slt_if.sv -----
interface slt_req_if;
   logic                                valid;
   logic                                ready;
   logic        [slt_pkg::ACTION_W-1:0] action;
   logic signed [slt_pkg::VALUE_W-1:0]  value;
   logic        [slt_pkg::INDEX_W-1:0]  index;

   modport source (output valid, output action, output value, output index, input ready);
   modport sink (input valid, input action, input value, input index, output ready);
endinterface

interface slt_rsp_if;
   logic                                valid;
   logic                                ready;
   logic        [slt_pkg::STATUS_W-1:0] status;
   logic signed [slt_pkg::VALUE_W-1:0]  entry;
   logic        [slt_pkg::COUNT_W-1:0]  count;
   logic                                empty_res;
   logic                                last;

   modport source (output valid, output status, output entry, output count,
                   output empty_res, output last, input ready);
   modport sink (input valid, input status, input entry, input count,
                 input empty_res, input last, output ready);
endinterface

// ----- hw/rtl/slt_datapath.sv -----
module slt_datapath #(
   parameter int DEPTH = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  slt_pkg::cmd_type                    cmd,
   input  logic        [slt_pkg::ACTION_W-1:0] req_action,
   input  logic signed [slt_pkg::VALUE_W-1:0]  req_value,
   input  logic        [slt_pkg::INDEX_W-1:0]  req_index,
   output slt_pkg::stat_type                   stat,
   output logic        [slt_pkg::STATUS_W-1:0] rsp_status,
   output logic signed [slt_pkg::VALUE_W-1:0]  rsp_entry,
   output logic        [slt_pkg::COUNT_W-1:0]  rsp_count,
   output logic                                rsp_empty_res,
   output logic                                rsp_last
);

   localparam int HW = $clog2(DEPTH + 1);

   logic        [slt_pkg::ACTION_W-1:0] action_ff;
   logic signed [slt_pkg::VALUE_W-1:0]  value_ff;
   logic        [slt_pkg::INDEX_W-1:0]  index_ff;

   logic signed [slt_pkg::VALUE_W-1:0]  cell_ff [DEPTH];
   logic signed [slt_pkg::VALUE_W-1:0]  cell_in [DEPTH];
   logic signed [slt_pkg::VALUE_W-1:0]  shift_dn [DEPTH];
   logic signed [slt_pkg::VALUE_W-1:0]  shift_up [DEPTH];
   logic        [DEPTH-1:0]             lt;
   logic        [DEPTH-1:0]             lt_prev;

   logic [HW-1:0] held_ff, held_in;
   logic [HW-1:0] held_dec;
   logic [HW-1:0] idx_ff, idx_in;

   logic [slt_pkg::STATUS_W-1:0] status_ff, status_in;
   logic signed [slt_pkg::VALUE_W-1:0] entry_ff, entry_in;
   logic [slt_pkg::COUNT_W-1:0]  count_ff, count_in;
   logic                         empty_ff, empty_in;
   logic                         last_ff, last_in;
   logic                         dump_ff, dump_in;

   assign held_dec = held_ff - HW'(1);

   // Per-cell compare and neighbor taps.
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         lt[i] = (HW'(i) < held_ff) && (cell_ff[i] < value_ff);
      end
      shift_dn[0] = value_ff;
      lt_prev[0]  = 1'b0;
      for (int i = 1; i < DEPTH; i++) begin
         shift_dn[i] = cell_ff[i-1];
         lt_prev[i]  = lt[i-1];
      end
      for (int i = 0; i < DEPTH - 1; i++) begin
         shift_up[i] = cell_ff[i+1];
      end
      shift_up[DEPTH-1] = cell_ff[DEPTH-1];
   end

   always_comb begin
      held_in = held_ff;
      for (int i = 0; i < DEPTH; i++) begin
         cell_in[i] = cell_ff[i];
      end
      case (cmd.op)
         slt_pkg::OP_INSERT: begin
            held_in = held_ff + HW'(1);
            for (int i = 0; i < DEPTH; i++) begin
               if (lt[i]) begin
                  cell_in[i] = cell_ff[i];
               end else if (i == 0 || lt_prev[i]) begin
                  cell_in[i] = value_ff;
               end else begin
                  cell_in[i] = shift_dn[i];
               end
            end
         end
         slt_pkg::OP_REMOVE: begin
            held_in = held_dec;
            for (int i = 0; i < DEPTH; i++) begin
               if (slt_pkg::COUNT_W'(i) < {1'b0, index_ff}) begin
                  cell_in[i] = cell_ff[i];
               end else begin
                  cell_in[i] = shift_up[i];
               end
            end
         end
         slt_pkg::OP_ROTATE: begin
            // Left rotation over the live entries; held beats restore the order.
            for (int i = 0; i < DEPTH; i++) begin
               if (HW'(i) == held_dec) begin
                  cell_in[i] = cell_ff[0];
               end else begin
                  cell_in[i] = shift_up[i];
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      status_in = status_ff;
      entry_in  = entry_ff;
      count_in  = count_ff;
      empty_in  = empty_ff;
      last_in   = last_ff;
      dump_in   = dump_ff;
      idx_in    = idx_ff;
      if (cmd.load_rsp) begin
         status_in = cmd.status;
         count_in  = slt_pkg::COUNT_W'(held_in);
         empty_in  = (held_in == '0);
         case (cmd.kind)
            slt_pkg::RK_DUMP_FIRST: begin
               entry_in = cell_ff[0];
               last_in  = (held_ff == HW'(1));
               dump_in  = 1'b1;
               idx_in   = '0;
            end
            slt_pkg::RK_DUMP_NEXT: begin
               entry_in = shift_up[0];
               last_in  = ({1'b0, idx_ff} + (HW+1)'(2)) == {1'b0, held_ff};
               dump_in  = 1'b1;
               idx_in   = idx_ff + HW'(1);
            end
            default: begin
               entry_in = '0;
               last_in  = 1'b1;
               dump_in  = 1'b0;
               idx_in   = '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= '0;
      end else begin
         held_ff <= held_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < DEPTH; i++) begin
         cell_ff[i] <= cell_in[i];
      end
      if (cmd.load_req) begin
         action_ff <= req_action;
         value_ff  <= req_value;
         index_ff  <= req_index;
      end
      status_ff <= status_in;
      entry_ff  <= entry_in;
      count_ff  <= count_in;
      empty_ff  <= empty_in;
      last_ff   <= last_in;
      dump_ff   <= dump_in;
      idx_ff    <= idx_in;
   end

   assign stat.action    = action_ff;
   assign stat.empty     = (held_ff == '0);
   assign stat.full      = (held_ff == HW'(DEPTH));
   assign stat.index_bad = {1'b0, index_ff} >= slt_pkg::COUNT_W'(held_ff);
   assign stat.rsp_last  = last_ff;
   assign stat.rsp_dump  = dump_ff;

   assign rsp_status    = status_ff;
   assign rsp_entry     = entry_ff;
   assign rsp_count     = count_ff;
   assign rsp_empty_res = empty_ff;
   assign rsp_last      = last_ff;

endmodule

// ----- hw/rtl/slt_controller.sv -----
module slt_controller (
   input  logic              clock,
   input  logic              reset,
   input  slt_pkg::stat_type stat,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output slt_pkg::cmd_type  cmd
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_RESP
   } state_type;

   state_type state_ff, state_in;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_RESP);

   always_comb begin
      state_in     = state_ff;
      cmd.load_req = 1'b0;
      cmd.op       = slt_pkg::OP_NONE;
      cmd.load_rsp = 1'b0;
      cmd.kind     = slt_pkg::RK_SINGLE;
      cmd.status   = slt_pkg::ST_OK;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = S_EXEC;
            end
         end
         S_EXEC: begin
            cmd.load_rsp = 1'b1;
            state_in     = S_RESP;
            case (stat.action)
               slt_pkg::ACT_INSERT: begin
                  if (stat.full) begin
                     cmd.status = slt_pkg::ST_FULL;
                  end else begin
                     cmd.op = slt_pkg::OP_INSERT;
                  end
               end
               slt_pkg::ACT_REMOVE: begin
                  if (stat.empty) begin
                     cmd.status = slt_pkg::ST_EMPTY;
                  end else if (stat.index_bad) begin
                     cmd.status = slt_pkg::ST_RANGE;
                  end else begin
                     cmd.op = slt_pkg::OP_REMOVE;
                  end
               end
               default: begin
                  // dump; the unused code decodes the same way
                  if (stat.empty) begin
                     cmd.status = slt_pkg::ST_EMPTY;
                  end else begin
                     cmd.kind = slt_pkg::RK_DUMP_FIRST;
                  end
               end
            endcase
         end
         S_RESP: begin
            if (rsp_ready) begin
               if (stat.rsp_dump) begin
                  cmd.op = slt_pkg::OP_ROTATE;
               end
               if (stat.rsp_last) begin
                  state_in = S_IDLE;
               end else begin
                  cmd.load_rsp = 1'b1;
                  cmd.kind     = slt_pkg::RK_DUMP_NEXT;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- hw/rtl/sorted_list_table_top.sv -----
// Sorted list table: up to DEPTH signed 32-bit values kept in ascending order.
// req_bus (sink) carries one command beat: action, value, index.
//   insert places value ahead of the first entry that is not smaller;
//   remove deletes the entry at index; dump streams every entry in order.
// rsp_bus (source) returns beats of status, entry, count, empty_res, last.
//   insert, remove and any refusal give one beat with last set;
//   a dump of N entries gives N beats, last set on the final one.
// Latency: a command beat is taken, the table updates in the next cycle and
// the first result beat is presented the cycle after that.
// Pacing: the next command is taken only after the last result beat of the
// current one; dump beats follow at one per cycle while rsp_bus.ready is high,
// paced by a left rotation of the cell row that leaves it in order after the
// last beat.
// Stall: while rsp_bus.ready is low the result beat holds and nothing changes.
// Reset clears the entry count and the controller; cell contents are not
// cleared and are never read before being written.
`include "sorted_list_table_top_defines.svh"

module sorted_list_table_top #(
   parameter int DEPTH = 16
) (
   input logic      clock,
   input logic      reset,
   slt_req_if.sink  req_bus,
   slt_rsp_if.source rsp_bus
);

   slt_pkg::cmd_type  cmd;
   slt_pkg::stat_type stat;

   slt_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .stat      (stat),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .cmd       (cmd)
   );

   slt_datapath #(
      .DEPTH (DEPTH)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .req_action    (req_bus.action),
      .req_value     (req_bus.value),
      .req_index     (req_bus.index),
      .stat          (stat),
      .rsp_status    (rsp_bus.status),
      .rsp_entry     (rsp_bus.entry),
      .rsp_count     (rsp_bus.count),
      .rsp_empty_res (rsp_bus.empty_res),
      .rsp_last      (rsp_bus.last)
   );

   `SLT_ASSERT_IMP(a_one_side, 1'b1, !(req_bus.ready && rsp_bus.valid), "req and rsp both open")
   `SLT_ASSERT_NXT(a_exec_gap, req_bus.valid && req_bus.ready, !rsp_bus.valid, "rsp too early")
   `SLT_ASSERT_IMP(a_count_max, rsp_bus.valid, rsp_bus.count <= slt_pkg::COUNT_W'(DEPTH), "count over depth")
   `SLT_ASSERT_IMP(a_empty_cnt, rsp_bus.valid, rsp_bus.empty_res == (rsp_bus.count == '0), "empty flag mismatch")

endmodule
